### hdl/pic_pkg.sv
// Shared types, codes and helper functions of the interrupt controller.
package pic_pkg;

   // Word kinds on the request channel.
   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_LINES = 2'd2,
      KIND_ACK   = 2'd3
   } kind_type;

   // Bus port addressed by a read or write (A0).
   typedef enum logic {
      PORT_CMD  = 1'b0,
      PORT_DATA = 1'b1
   } port_type;

   // Initialization sequence position.
   typedef enum logic [1:0] {
      INIT_DONE = 2'd0,
      INIT_ICW2 = 2'd1,
      INIT_ICW3 = 2'd2,
      INIT_ICW4 = 2'd3
   } init_type;

   localparam int unsigned NUM_LINES   = 8;
   localparam logic [3:0]  NO_LEVEL    = 4'd8;
   localparam logic [2:0]  SPUR_LEVEL  = 3'd7;
   localparam logic [7:0]  MASK_RESET  = 8'hFF;
   localparam logic [7:0]  LINES_ARMED = 8'hFF;

   // Command byte decode.
   localparam int unsigned ICW1_BIT     = 4;
   localparam int unsigned OCW3_BIT     = 3;
   localparam logic [1:0]  OCW2_NONSPEC = 2'b01;
   localparam logic [1:0]  OCW2_SPEC    = 2'b11;

   typedef struct packed {
      logic [7:0] request;
      logic [7:0] in_service;
      logic [7:0] mask;
      logic [4:0] vector_base;
      init_type   init_step;
      logic       needs_icw4;
      logic       single_mode;
      logic       level_mode;
      logic       auto_eoi;
      logic       read_isr;
      logic [7:0] cascade_word;
      logic [7:0] prev_lines;
   } pic_state_type;

   localparam pic_state_type PIC_STATE_RESET = '{
      request:      8'h00,
      in_service:   8'h00,
      mask:         MASK_RESET,
      vector_base:  5'd0,
      init_step:    INIT_DONE,
      needs_icw4:   1'b0,
      single_mode:  1'b0,
      level_mode:   1'b0,
      auto_eoi:     1'b0,
      read_isr:     1'b0,
      cascade_word: 8'h00,
      prev_lines:   8'h00
   };

   // Lowest set bit (line 0 highest priority), NO_LEVEL when empty.
   function automatic logic [3:0] best_level(input logic [7:0] v);
      logic [3:0] lvl;
      lvl = NO_LEVEL;
      for (int i = NUM_LINES - 1; i >= 0; i--) begin
         if (v[i]) begin
            lvl = 4'(i);
         end
      end
      return lvl;
   endfunction

   // Level that an acknowledge would grant now, NO_LEVEL if none.
   function automatic logic [3:0] grant_level(input pic_state_type s);
      logic [3:0] req;
      logic [3:0] svc;
      req = best_level(s.request & ~s.mask);
      svc = best_level(s.in_service);
      return (req != NO_LEVEL && req < svc) ? req : NO_LEVEL;
   endfunction

endpackage

### hdl/programmable_interrupt_controller.sv
// Top level of the 8259-style programmable interrupt controller.
// One single-chip 8259-style controller in fully nested mode, driven by a stream of
// bus cycles. Each request word is a command/data port write, a port read, a sample
// of the eight IR lines, or an interrupt acknowledge; each produces exactly one
// response word carrying the read byte, the interrupt output level after the cycle,
// the acknowledge vector and a spurious flag. A word is registered on entry, resolved
// by one pass of priority and update logic, and registered again on exit; the block
// takes one word per clock while the response is not stalled. Both stages advance
// together whenever the response register is empty or being taken, so a stalled
// response stops intake only once both stages are full. Priority is fixed with
// line 0 highest; rotation, poll, special mask and cascading are absent.
module programmable_interrupt_controller (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [7:0] write_data, [15:8] request_lines
   input  logic [15:0] req_tdata,
   // req_tuser: [1:0] kind, [2] port_select
   input  logic [2:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: [7:0] read_data, [8] interrupt_out, [16:9] vector, [23:17] zero
   output logic [23:0] rsp_tdata,
   // rsp_tuser: [0] spurious
   output logic        rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);
   import pic_pkg::*;

   // Input stage.
   logic          in_valid_ff;
   logic          in_valid_in;
   kind_type      in_kind_ff;
   port_type      in_port_ff;
   logic [7:0]    in_wdata_ff;
   logic [7:0]    in_lines_ff;

   // Controller state.
   pic_state_type state_ff;
   pic_state_type state_in;

   // Output stage.
   logic          out_valid_ff;
   logic          out_valid_in;
   logic [7:0]    out_rdata_ff;
   logic          out_irq_ff;
   logic [7:0]    out_vector_ff;
   logic          out_spur_ff;

   logic          advance;
   logic          fire;
   logic          in_take;
   logic [7:0]    core_rdata;
   logic          core_irq;
   logic [7:0]    core_vector;
   logic          core_spur;

   // Both stages move when the response register can take a word.
   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign in_take    = req_tvalid && req_tready;

   assign in_valid_in  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   pic_core u_core (
      .cur_state     (state_ff),
      .kind          (in_kind_ff),
      .port_select   (in_port_ff),
      .write_data    (in_wdata_ff),
      .request_lines (in_lines_ff),
      .nxt_state     (state_in),
      .read_data     (core_rdata),
      .interrupt_out (core_irq),
      .vector        (core_vector),
      .spurious      (core_spur)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= PIC_STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers: capture on accept, hold while stalled.
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_kind_ff  <= kind_type'(req_tuser[1:0]);
         in_port_ff  <= port_type'(req_tuser[2]);
         in_wdata_ff <= req_tdata[7:0];
         in_lines_ff <= req_tdata[15:8];
      end
      if (fire) begin
         out_rdata_ff  <= core_rdata;
         out_irq_ff    <= core_irq;
         out_vector_ff <= core_vector;
         out_spur_ff   <= core_spur;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_vector_ff, out_irq_ff, out_rdata_ff};
   assign rsp_tuser  = out_spur_ff;

   // A spurious acknowledge always reports the line-7 vector.
   a_spur_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[11:9] == SPUR_LEVEL)
      else $error("spurious response without line-7 vector");

   // A granted acknowledge without auto-EOI leaves a level in service.
   a_ack_service: assert property (@(posedge clock) disable iff (reset)
      fire && in_kind_ff == KIND_ACK && !core_spur && !state_ff.auto_eoi
      |=> state_ff.in_service != 8'h00)
      else $error("granted acknowledge set no in-service bit");

   // A granted level was pending and unmasked.
   a_ack_pending: assert property (@(posedge clock) disable iff (reset)
      fire && in_kind_ff == KIND_ACK && !core_spur
      |-> (state_ff.request & ~state_ff.mask) != 8'h00)
      else $error("acknowledge granted with nothing pending");

   // An empty input stage never refuses a word.
   a_intake_free: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("empty input stage refused a word");

endmodule

### hdl/pic_core.sv
// Next-state and result logic for one bus cycle of the interrupt controller.
module pic_core (
   input  pic_pkg::pic_state_type cur_state,
   input  pic_pkg::kind_type      kind,
   input  pic_pkg::port_type      port_select,
   input  logic [7:0]             write_data,
   input  logic [7:0]             request_lines,
   output pic_pkg::pic_state_type nxt_state,
   output logic [7:0]             read_data,
   output logic                   interrupt_out,
   output logic [7:0]             vector,
   output logic                   spurious
);
   import pic_pkg::*;

   logic       cmd_write;
   logic       data_write;
   logic       is_icw1;
   logic [3:0] grant;
   logic [3:0] svc_top;
   init_type   init_nxt;

   assign cmd_write  = (kind == KIND_WRITE) && (port_select == PORT_CMD);
   assign data_write = (kind == KIND_WRITE) && (port_select == PORT_DATA);
   assign is_icw1    = cmd_write && write_data[ICW1_BIT];
   assign grant      = grant_level(cur_state);
   assign svc_top    = best_level(cur_state.in_service);

   // Init sequence step: ICW1 restarts, data writes advance.
   always_comb begin
      init_nxt = cur_state.init_step;
      if (is_icw1) begin
         init_nxt = INIT_ICW2;
      end else if (data_write) begin
         unique case (cur_state.init_step)
            INIT_ICW2: begin
               if (!cur_state.single_mode) begin
                  init_nxt = INIT_ICW3;
               end else begin
                  init_nxt = cur_state.needs_icw4 ? INIT_ICW4 : INIT_DONE;
               end
            end
            INIT_ICW3: init_nxt = cur_state.needs_icw4 ? INIT_ICW4 : INIT_DONE;
            INIT_ICW4: init_nxt = INIT_DONE;
            default:   init_nxt = INIT_DONE;
         endcase
      end
   end

   // Registers, results.
   always_comb begin
      nxt_state = cur_state;
      read_data = 8'h00;
      vector    = 8'h00;
      spurious  = 1'b0;
      unique case (kind)
         KIND_WRITE: begin
            if (port_select == PORT_CMD) begin
               if (write_data[ICW1_BIT]) begin
                  nxt_state.needs_icw4  = write_data[0];
                  nxt_state.single_mode = write_data[1];
                  nxt_state.level_mode  = write_data[3];
                  if (!write_data[0]) begin
                     nxt_state.auto_eoi = 1'b0;
                  end
                  nxt_state.request    = 8'h00;
                  nxt_state.in_service = 8'h00;
                  nxt_state.mask       = 8'h00;
                  nxt_state.read_isr   = 1'b0;
                  nxt_state.prev_lines = LINES_ARMED;
               end else if (write_data[OCW3_BIT]) begin
                  if (write_data[1]) begin
                     nxt_state.read_isr = write_data[0];
                  end
               end else if (write_data[6:5] == OCW2_NONSPEC) begin
                  if (svc_top != NO_LEVEL) begin
                     nxt_state.in_service[svc_top[2:0]] = 1'b0;
                  end
               end else if (write_data[6:5] == OCW2_SPEC) begin
                  nxt_state.in_service[write_data[2:0]] = 1'b0;
               end
            end else begin
               case (cur_state.init_step)
                  INIT_ICW2: nxt_state.vector_base  = write_data[7:3];
                  INIT_ICW3: nxt_state.cascade_word = write_data;
                  INIT_ICW4: nxt_state.auto_eoi     = write_data[1];
                  default:   nxt_state.mask         = write_data;
               endcase
            end
         end
         KIND_READ: begin
            if (port_select == PORT_CMD) begin
               read_data = cur_state.read_isr ? cur_state.in_service : cur_state.request;
            end else begin
               read_data = cur_state.mask;
            end
         end
         KIND_LINES: begin
            if (cur_state.level_mode) begin
               nxt_state.request = request_lines;
            end else begin
               nxt_state.request = cur_state.request | (request_lines & ~cur_state.prev_lines);
            end
            nxt_state.prev_lines = request_lines;
         end
         KIND_ACK: begin
            if (grant != NO_LEVEL) begin
               nxt_state.request[grant[2:0]] = 1'b0;
               if (!cur_state.auto_eoi) begin
                  nxt_state.in_service[grant[2:0]] = 1'b1;
               end
               vector = {cur_state.vector_base, grant[2:0]};
            end else begin
               vector   = {cur_state.vector_base, SPUR_LEVEL};
               spurious = 1'b1;
            end
         end
         default: ;
      endcase
      nxt_state.init_step = init_nxt;
   end

   assign interrupt_out = (grant_level(nxt_state) != NO_LEVEL);

endmodule
